// ----- src/tcw_pkg.sv -----
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Action codes carried on the input tuser
    localparam logic [1:0] ACT_TELETYPE = 2'd0;
    localparam logic [1:0] ACT_PLACED   = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;
    localparam logic [1:0] ACT_READ     = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COLF_W   = 7;
    localparam int ROWF_W   = 5;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch the input transfer
        logic exec;        // perform the single-cycle part of the item
        logic fill;        // write the sweep address with the fill cell
        logic fill_blank;  // fill with spaces rather than zeros
        logic scroll;      // move one cell up a row
        logic load_out;    // load the result register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] action;
        logic       wrap;        // teletype advance leaves the last row
        logic       sweep_last;  // sweep address is on the last cell
    } status_t;

endpackage

// ----- src/text_console_writer.sv -----
// Top level of the text console writer: controller, datapath and assertions.
`timescale 1ns / 1ps

// Character-cell text console of COLUMNS x ROWS cells (character low byte,
// attribute high byte), with a cursor that advances on teletype writes.
// Input channel (s_*): one transfer is one command; s_tuser carries the action
// (teletype write, placed write, clear, read). Output channel (m_*): exactly
// one result transfer per command with the cursor after it, a scroll flag and
// the cell that was read. cfg_* writes the default attribute; always ready.
// Timing: a teletype or placed write loads its result in the execute state, or in
// the done state while the output register is full; a read loads in the done state
// (registered memory read). The next command is taken once back in idle.
// A clear sweeps every cell, one write per cycle.
// A teletype write that leaves the last row (newline or last column) scrolls by
// copying each cell up one row through the single memory read and write port,
// one cell per cycle. One command is in work at a time.
// Reset: the cursor homes, the default attribute becomes 15 and the cell
// store is swept to zero with s_tready held low.
// Stall: a finished result waits in the output register; the next command
// may still be accepted and runs until its own result needs that register.
module text_console_writer
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: default attribute
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // Commands
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // character[7:0], attribute[15:8], column[22:16],
                                   // row[27:23], at_cursor[28], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cursor_column[6:0], cursor_row[11:7], scrolled[12],
                                   // cell_char[20:13], cell_attribute[28:21], zero fill
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t stat;

    // Configuration transfers are taken at any time
    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcw_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

    // One command at a time: drop ready after each accepted transfer
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while another is in work");

    // A scroll always leaves the cursor at column 0 of the last row
    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[12]) |->
            (m_tdata[6:0] == 7'd0) && ((ROWS > 32) || (m_tdata[11:7] == 5'(ROWS - 1))))
        else $error("scroll result with cursor off the start of the last row");

    // The reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((COLUMNS > 128) || (32'(m_tdata[6:0]) < COLUMNS)) &&
                     ((ROWS > 32) || (32'(m_tdata[11:7]) < ROWS)))
        else $error("cursor outside the screen");

endmodule

// ----- src/tcw_ctrl.sv -----
// Controller state machine of the text console writer.
`timescale 1ns / 1ps

module tcw_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  tcw_pkg::status_t stat,
    output tcw_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.fill = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.action == tcw_pkg::ACT_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else if (stat.action == tcw_pkg::ACT_TELETYPE && stat.wrap)
                begin
                    state_next = S_SCROLL;
                end
                else if (stat.action != tcw_pkg::ACT_READ && out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                cmd.fill       = 1'b1;
                cmd.fill_blank = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCROLL:
            begin
                cmd.scroll = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/tcw_datapath.sv -----
// Datapath of the text console writer: cursor, cell store, sweep and result register.
`timescale 1ns / 1ps

module tcw_datapath
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [tcw_pkg::ATTR_W-1:0] cfg_data,
    input  logic [tcw_pkg::IN_W-1:0]   s_tdata,
    input  logic [tcw_pkg::ACTION_W-1:0] s_tuser,
    input  tcw_pkg::cmd_t              cmd,
    output tcw_pkg::status_t           stat,
    output logic [tcw_pkg::OUT_W-1:0]  m_tdata
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // Configuration register
    logic [tcw_pkg::ATTR_W-1:0] def_attr_reg;

    // Latched item
    logic [1:0]                 act_reg;
    logic [tcw_pkg::CHAR_W-1:0] ch_reg;
    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic [tcw_pkg::COLF_W-1:0] col_reg;
    logic [tcw_pkg::ROWF_W-1:0] row_reg;
    logic                       atc_reg;

    // Cursor
    logic [COL_W-1:0] cur_col_reg;
    logic [COL_W-1:0] cur_col_next;
    logic [ROW_W-1:0] cur_row_reg;
    logic [ROW_W-1:0] cur_row_next;
    logic             scrolled_reg;
    logic             scrolled_next;

    // Sweep and delayed scroll write
    logic [ADDR_W-1:0] sweep_reg;
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              pend_mem_reg;
    logic              scroll_src_ok;

    // Cell store
    logic [15:0]       mem [CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       rd_data_reg;

    // Result register
    logic [tcw_pkg::COLF_W-1:0] out_col_reg;
    logic [tcw_pkg::ROWF_W-1:0] out_row_reg;
    logic                       out_scr_reg;
    logic [tcw_pkg::CHAR_W-1:0] out_ch_reg;
    logic [tcw_pkg::ATTR_W-1:0] out_attr_reg;

    logic                       in_range;
    logic                       is_newline;
    logic                       col_last;
    logic                       row_last;
    logic [ADDR_W-1:0]          cursor_addr;
    logic [ADDR_W-1:0]          target_addr;
    logic [tcw_pkg::ATTR_W-1:0] eff_attr;
    logic [15:0]                item_cell;
    logic                       read_hit;

    assign in_range    = (32'(col_reg) < 32'(COLUMNS)) && (32'(row_reg) < 32'(ROWS));
    assign is_newline  = (ch_reg == tcw_pkg::NEWLINE_CODE);
    assign col_last    = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign row_last    = (cur_row_reg == ROW_W'(ROWS - 1));
    assign cursor_addr = ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);
    assign target_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign eff_attr    = (attr_reg != '0) ? attr_reg : def_attr_reg;
    assign item_cell   = {eff_attr, ch_reg};
    assign read_hit    = (act_reg == tcw_pkg::ACT_READ) && in_range;
    assign scroll_src_ok = (32'(sweep_reg) < CELLS - COLUMNS);

    assign stat.action     = act_reg;
    assign stat.wrap       = (is_newline || col_last) && row_last;
    assign stat.sweep_last = (sweep_reg == ADDR_W'(CELLS - 1));

    // Cursor update for the executing item
    always_comb
    begin
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        scrolled_next = scrolled_reg;
        if (cmd.exec)
        begin
            scrolled_next = 1'b0;
            case (act_reg)
                tcw_pkg::ACT_TELETYPE:
                begin
                    if (is_newline || col_last)
                    begin
                        cur_col_next = '0;
                        if (row_last)
                        begin
                            scrolled_next = 1'b1;
                        end
                        else
                        begin
                            cur_row_next = cur_row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg + COL_W'(1);
                    end
                end
                tcw_pkg::ACT_CLEAR:
                begin
                    cur_col_next = '0;
                    cur_row_next = '0;
                end
                default:
                begin
                    cur_col_next = cur_col_reg;
                end
            endcase
        end
    end

    // Write port: pending scroll write first, then sweep fill, then item write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = '0;
        if (pend_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = pend_mem_reg ? rd_data_reg : 16'd0;
        end
        else if (cmd.fill)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = cmd.fill_blank ? {def_attr_reg, tcw_pkg::SPACE_CODE} : 16'd0;
        end
        else if (cmd.exec && !is_newline)
        begin
            mem_wdata = item_cell;
            if (act_reg == tcw_pkg::ACT_TELETYPE)
            begin
                mem_we    = 1'b1;
                mem_waddr = cursor_addr;
            end
            else if (act_reg == tcw_pkg::ACT_PLACED)
            begin
                mem_we    = atc_reg || in_range;
                mem_waddr = atc_reg ? cursor_addr : target_addr;
            end
        end
    end

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = target_addr;
        if (cmd.scroll)
        begin
            mem_re    = scroll_src_ok;
            mem_raddr = sweep_reg + ADDR_W'(COLUMNS);
        end
        else if (cmd.exec && read_hit)
        begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_attr_reg   <= 8'd15;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            scrolled_reg   <= 1'b0;
            sweep_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                def_attr_reg <= cfg_data;
            end
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            scrolled_reg   <= scrolled_next;
            pend_valid_reg <= cmd.scroll;
            if (cmd.fill || cmd.scroll)
            begin
                sweep_reg <= stat.sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= sweep_reg;
        pend_mem_reg  <= scroll_src_ok;
        if (cmd.accept)
        begin
            act_reg  <= s_tuser;
            ch_reg   <= s_tdata[7:0];
            attr_reg <= s_tdata[15:8];
            col_reg  <= s_tdata[22:16];
            row_reg  <= s_tdata[27:23];
            atc_reg  <= s_tdata[28];
        end
        if (cmd.load_out)
        begin
            out_col_reg  <= tcw_pkg::COLF_W'(cur_col_next);
            out_row_reg  <= tcw_pkg::ROWF_W'(cur_row_next);
            out_scr_reg  <= scrolled_next;
            out_ch_reg   <= read_hit ? rd_data_reg[7:0] : 8'd0;
            out_attr_reg <= read_hit ? rd_data_reg[15:8] : 8'd0;
        end
    end

    assign m_tdata = {3'b000, out_attr_reg, out_ch_reg, out_scr_reg, out_row_reg, out_col_reg};

endmodule
